@@ rtl/trs_pkg.sv @@
// shared types and constants of the target retarget selector
package trs_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int THR_W      = 16;
  localparam int SLOT_W     = 3;
  localparam int ARMOR_W    = 4;
  localparam int PRIO_W     = 4;
  localparam int CONF_W     = 16;
  localparam int TIME_W     = 32;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;

  localparam logic [THR_W-1:0] THR_RESET = 16'd2731;

  // one candidate as ranked by the back end
  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic [ARMOR_W-1:0]    armor;
    logic [PRIO_W-1:0]     prio;
    logic [CONF_W-1:0]     conf;
    logic [TIME_W-1:0]     stamp;
    logic [ANGLE_BITS-1:0] yaw;
    logic [ANGLE_BITS-1:0] ang_dist;
    logic                  cont;
  } rank_t;

  // classified item travelling from front to back
  typedef struct packed {
    rank_t cand;
    logic  ref_valid;
    logic  cooldown;
    logic  last;
  } cls_item_t;

endpackage

@@ rtl/trs_front.sv @@
// front end: unpacks an input item, computes wrapped distance and continuation
module trs_front (
  input  logic [trs_pkg::IN_DATA_W-1:0] in_data,
  input  logic                          in_last,
  input  logic [trs_pkg::THR_W-1:0]     threshold,
  output trs_pkg::cls_item_t            item
);

  localparam logic [trs_pkg::ANGLE_BITS-1:0] HALF_TURN =
    {1'b1, {(trs_pkg::ANGLE_BITS-1){1'b0}}};

  logic [trs_pkg::SLOT_W-1:0]     cand_slot;
  logic [trs_pkg::ARMOR_W-1:0]    cand_armor;
  logic [trs_pkg::PRIO_W-1:0]     cand_priority;
  logic [trs_pkg::CONF_W-1:0]     cand_confidence;
  logic [trs_pkg::TIME_W-1:0]     cand_time;
  logic [trs_pkg::ANGLE_BITS-1:0] cand_yaw;
  logic                           ref_valid;
  logic [trs_pkg::SLOT_W-1:0]     ref_slot;
  logic [trs_pkg::ARMOR_W-1:0]    ref_armor;
  logic [trs_pkg::ANGLE_BITS-1:0] anchor_yaw;
  logic                           cd_running;
  logic [trs_pkg::ANGLE_BITS-1:0] diff;
  logic [trs_pkg::ANGLE_BITS-1:0] ang_dist;

  assign cand_slot       = in_data[2:0];
  assign cand_armor      = in_data[6:3];
  assign cand_priority   = in_data[10:7];
  assign cand_confidence = in_data[26:11];
  assign cand_time       = in_data[58:27];
  assign cand_yaw        = in_data[74:59];
  assign ref_valid       = in_data[75];
  assign ref_slot        = in_data[78:76];
  assign ref_armor       = in_data[82:79];
  assign anchor_yaw      = in_data[98:83];
  assign cd_running      = in_data[99];

  // difference mod full turn, folded onto the shorter way round
  assign diff     = cand_yaw - anchor_yaw;
  assign ang_dist = (diff > HALF_TURN) ? (~diff + 1'b1) : diff;

  always_comb begin
    item.cand.slot     = cand_slot;
    item.cand.armor    = cand_armor;
    item.cand.prio     = cand_priority;
    item.cand.conf     = cand_confidence;
    item.cand.stamp    = cand_time;
    item.cand.yaw      = cand_yaw;
    item.cand.ang_dist = ang_dist;
    item.cand.cont     = ref_valid && (cand_slot == ref_slot) && (cand_armor == ref_armor)
                         && (ang_dist < threshold);
    item.ref_valid     = ref_valid;
    item.cooldown      = cd_running;
    item.last          = in_last;
  end

endmodule

@@ rtl/trs_queue.sv @@
// small queue of classified items between front and back
module trs_queue #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  trs_pkg::cls_item_t push_item,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output trs_pkg::cls_item_t head_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  trs_pkg::cls_item_t slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_full  = (count_r != CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head_item = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

@@ rtl/trs_back.sv @@
// back end: running best per frame, retarget decision and result register
module trs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [trs_pkg::THR_W-1:0]      threshold,
  input  logic                           head_valid,
  input  trs_pkg::cls_item_t             head_item,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [trs_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic                           have_best_r, have_best_nxt;
  trs_pkg::rank_t                 best_r;
  trs_pkg::rank_t                 win;
  trs_pkg::rank_t                 cand;
  logic                           ahead;
  logic                           big_jump;
  logic                           blocked;
  logic                           accepted;
  logic                           out_valid_r, out_valid_nxt;
  logic [trs_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign cand = head_item.cand;

  // lexicographic rank: strictly ahead of the stored best
  always_comb begin
    if (cand.prio != best_r.prio) begin
      ahead = cand.prio < best_r.prio;
    end else if (head_item.ref_valid && (cand.cont != best_r.cont)) begin
      ahead = cand.cont;
    end else if (cand.ang_dist != best_r.ang_dist) begin
      ahead = cand.ang_dist < best_r.ang_dist;
    end else if (cand.conf != best_r.conf) begin
      ahead = cand.conf > best_r.conf;
    end else if (cand.stamp != best_r.stamp) begin
      ahead = cand.stamp > best_r.stamp;
    end else if (cand.slot != best_r.slot) begin
      ahead = cand.slot < best_r.slot;
    end else begin
      ahead = cand.armor < best_r.armor;
    end
  end

  assign win = (!have_best_r || ahead) ? cand : best_r;

  assign big_jump = !win.cont && (win.ang_dist >= threshold);
  assign blocked  = big_jump && head_item.cooldown && head_item.ref_valid;
  assign accepted = !blocked;

  // a non-last item never waits on the result register
  assign pop = head_valid && (!head_item.last || !out_valid_r || out_tready);

  always_comb begin
    have_best_nxt = have_best_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      have_best_nxt = !head_item.last;
      if (head_item.last) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {1'b0, accepted && big_jump, blocked, accepted, win.cont,
                         win.ang_dist, win.yaw, win.conf, win.prio, win.armor, win.slot};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      have_best_r <= have_best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop) begin
      best_r <= win;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_item.last) |=> !have_best_r && out_valid_r)
    else $error("last item did not close the frame");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(pop && head_item.last))
    else $error("result without a last item");

endmodule

@@ rtl/target_retarget_selector_core.sv @@
// top level of the target retarget selector
// Picks one target per frame of candidates and decides whether the retarget
// is allowed. Candidates stream in one item per cycle; the item with tlast
// set closes the frame and produces exactly one result holding the winner
// and the decision flags. Sustained rate is one item per clock: the front
// end classifies each item in its accept cycle (wrapped yaw subtract plus
// continuation compare) and writes it to a QUEUE_DEPTH-entry queue, and the
// back end folds one queued item per clock into the running best with one
// lexicographic compare. A last item reaches out_tvalid through the queue
// and then the result register. Only a last item waits on a full result
// register; when the queue fills, in_tready drops. The user must write the
// retarget threshold through cfg_wr_en/cfg_wr_data while idle; not enforced.
module target_retarget_selector_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // cfg port: retarget threshold
  input  logic                           cfg_wr_en,
  input  logic [trs_pkg::THR_W-1:0]      cfg_wr_data,
  // candidate stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // from bit 0: cand_slot, cand_armor, cand_priority, cand_confidence,
  // cand_time, cand_yaw, ref_valid, ref_slot, ref_armor, anchor_yaw,
  // cooldown flag, zero pad
  input  logic [trs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,   // last_in_frame
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // from bit 0: win_slot, win_armor, win_priority, win_confidence, win_yaw,
  // win_distance, is_continuation, accepted, blocked_by_cooldown,
  // start_cooldown, zero pad
  output logic [trs_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [trs_pkg::THR_W-1:0] threshold_r;
  trs_pkg::cls_item_t        front_item;
  trs_pkg::cls_item_t        head_item;
  logic                      q_not_full;
  logic                      q_not_empty;
  logic                      push;
  logic                      pop;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= trs_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  assign in_tready = q_not_full;
  assign push      = in_tvalid && q_not_full;

  // classify on the way in
  trs_front u_front (
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .threshold (threshold_r),
    .item      (front_item)
  );

  // decouples intake from the ranking loop
  trs_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // running best and result register
  trs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .threshold  (threshold_r),
    .head_valid (q_not_empty),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
